// ===== src/ose_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ose_pkg
// Shared types and constants of the operand stack engine: request and result
// words, opcodes, error codes, controller states and control/status bundles.
// ----------------------------------------------------------------------------
package ose_pkg;

    // storage geometry
    localparam int DEPTH      = 1024;
    localparam int WORD_BITS  = 64;
    localparam int ADDR_BITS  = $clog2(DEPTH);
    localparam int SP_BITS    = $clog2(DEPTH + 1);

    // field widths of the request and result words
    localparam int OPCODE_BITS = 3;
    localparam int VALUE_BITS  = 64;
    localparam int COUNT_BITS  = 11;
    localparam int DATA_BITS   = 64;
    localparam int ERROR_BITS  = 2;
    localparam int OCC_BITS    = 11;

    // width used for count against pointer compares
    localparam int CMP_BITS = (SP_BITS > COUNT_BITS) ? SP_BITS + 1 : COUNT_BITS + 1;

    // opcodes
    localparam logic [OPCODE_BITS-1:0] OP_PUSH     = 3'd0;
    localparam logic [OPCODE_BITS-1:0] OP_POP      = 3'd1;
    localparam logic [OPCODE_BITS-1:0] OP_RESERVE  = 3'd2;
    localparam logic [OPCODE_BITS-1:0] OP_DROP     = 3'd3;
    localparam logic [OPCODE_BITS-1:0] OP_REVERSE  = 3'd4;
    localparam logic [OPCODE_BITS-1:0] OP_PEEK_TOP = 3'd5;
    localparam logic [OPCODE_BITS-1:0] OP_PEEK_BOT = 3'd6;

    // error codes
    localparam logic [ERROR_BITS-1:0] ERR_OK    = 2'd0;
    localparam logic [ERROR_BITS-1:0] ERR_OVER  = 2'd1;
    localparam logic [ERROR_BITS-1:0] ERR_UNDER = 2'd2;

    // request word
    typedef struct packed {
        logic [OPCODE_BITS-1:0] opcode;
        logic [VALUE_BITS-1:0]  value;
        logic [COUNT_BITS-1:0]  count;
    } req_t;

    // result word
    typedef struct packed {
        logic [DATA_BITS-1:0]  data;
        logic [ERROR_BITS-1:0] error;
        logic [OCC_BITS-1:0]   occupancy;
    } res_t;

    // controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_READ,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_SWAP_C,
        ST_SWAP_D
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;       // capture request word
        logic clr_write;  // zero one store entry, advance sweep
        logic rd_op;      // read entry addressed by pop or peek
        logic rev_init;   // set up swap pointers
        logic rd_lo;      // read lower swap entry
        logic rd_hi;      // read upper swap entry, hold lower word
        logic wr_lo;      // write upper word into lower entry
        logic wr_hi;      // write held lower word into upper entry, step pointers
        logic finish;     // commit pointer, load result, raise strobe
        logic fin_rdata;  // result data comes from the store read
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic [OPCODE_BITS-1:0] opcode;
        logic                   fault;
        logic                   rev_multi;
        logic                   lo_lt_hi;
        logic                   clr_last;
    } ctrl_status_t;

endpackage
`default_nettype wire

// ===== src/ose_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ose_ctrl
// Controller of the operand stack engine: clears the store after reset,
// sequences each request and walks the swap loop of a reverse.
// ----------------------------------------------------------------------------
module ose_ctrl (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   start,
    input  ose_pkg::ctrl_status_t status,
    output ose_pkg::ctrl_cmd_t    cmd,
    output logic                  busy
);
    import ose_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (status.fault)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.opcode == OP_POP || status.opcode == OP_PEEK_TOP ||
                         status.opcode == OP_PEEK_BOT)
                begin
                    state_next = ST_READ;
                end
                else if (status.opcode == OP_REVERSE && status.rev_multi)
                begin
                    state_next = ST_SWAP_A;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            ST_SWAP_A:
            begin
                state_next = status.lo_lt_hi ? ST_SWAP_B : ST_IDLE;
            end
            ST_SWAP_B:
            begin
                state_next = ST_SWAP_C;
            end
            ST_SWAP_C:
            begin
                state_next = ST_SWAP_D;
            end
            ST_SWAP_D:
            begin
                state_next = ST_SWAP_A;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_write = 1'b1;
            end
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_DECODE:
            begin
                if (status.fault)
                begin
                    cmd.finish = 1'b1;
                end
                else if (status.opcode == OP_POP || status.opcode == OP_PEEK_TOP ||
                         status.opcode == OP_PEEK_BOT)
                begin
                    cmd.rd_op = 1'b1;
                end
                else if (status.opcode == OP_REVERSE && status.rev_multi)
                begin
                    cmd.rev_init = 1'b1;
                end
                else
                begin
                    cmd.finish = 1'b1;
                end
            end
            ST_READ:
            begin
                cmd.finish    = 1'b1;
                cmd.fin_rdata = 1'b1;
            end
            ST_SWAP_A:
            begin
                if (status.lo_lt_hi)
                begin
                    cmd.rd_lo = 1'b1;
                end
                else
                begin
                    cmd.finish = 1'b1;
                end
            end
            ST_SWAP_B:
            begin
                cmd.rd_hi = 1'b1;
            end
            ST_SWAP_C:
            begin
                cmd.wr_lo = 1'b1;
            end
            ST_SWAP_D:
            begin
                cmd.wr_hi = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

`ifndef SYNTHESIS
    // an accepted word always makes the engine busy on the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("engine not busy after accepting a word");

    // no result while the store is still being cleared
    a_no_finish_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !cmd.finish)
        else $error("result issued during store clear");

    // at most one store write source per cycle
    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clr_write, cmd.wr_lo, cmd.wr_hi,
                  cmd.finish && status.opcode == OP_PUSH && !status.fault}))
        else $error("conflicting store writes");

    // at most one store read source per cycle
    a_one_read: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.rd_op, cmd.rd_lo, cmd.rd_hi}))
        else $error("conflicting store reads");

    // a swap write pair follows its reads
    a_swap_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_hi |-> $past(cmd.wr_lo) && $past(cmd.rd_hi, 2))
        else $error("swap sequence out of order");
`endif

endmodule
`default_nettype wire

// ===== src/ose_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ose_dp
// Datapath of the operand stack engine: word store, stack pointer, swap
// pointers, bounds checks and the registered result word.
// ----------------------------------------------------------------------------
module ose_dp (
    input  wire                   clk,
    input  wire                   rst_n,
    input  ose_pkg::req_t         req,
    input  ose_pkg::ctrl_cmd_t    cmd,
    output ose_pkg::ctrl_status_t status,
    output logic                  done,
    output ose_pkg::res_t         result
);
    import ose_pkg::*;

    // word store
    logic [WORD_BITS-1:0] mem [DEPTH];

    req_t                 req_reg;
    logic [SP_BITS-1:0]   sp_reg;
    logic [SP_BITS-1:0]   sp_next;
    logic [ADDR_BITS-1:0] clr_cnt_reg;
    logic [ADDR_BITS-1:0] lo_reg;
    logic [ADDR_BITS-1:0] hi_reg;
    logic [WORD_BITS-1:0] tmp_reg;
    logic [WORD_BITS-1:0] rdata_reg;
    res_t                 result_reg;
    logic                 done_reg;

    logic [CMP_BITS-1:0]   cnt_ext;
    logic [CMP_BITS-1:0]   sp_ext;
    logic [CMP_BITS-1:0]   occ_ext;
    logic [ERROR_BITS-1:0] err_code;
    logic [ADDR_BITS-1:0]  op_addr;
    logic                  push_write;
    logic                  mem_we;
    logic [ADDR_BITS-1:0]  mem_waddr;
    logic [WORD_BITS-1:0]  mem_wdata;
    logic                  mem_re;
    logic [ADDR_BITS-1:0]  mem_raddr;

    // operand extensions
    assign cnt_ext = CMP_BITS'(req_reg.count);
    assign sp_ext  = CMP_BITS'(sp_reg);
    assign occ_ext = CMP_BITS'(DEPTH) - sp_ext;

    // bounds checks
    always_comb
    begin
        err_code = ERR_OK;
        unique case (req_reg.opcode)
            OP_PUSH:
            begin
                if (sp_ext == '0)
                begin
                    err_code = ERR_OVER;
                end
            end
            OP_POP:
            begin
                if (occ_ext == '0)
                begin
                    err_code = ERR_UNDER;
                end
            end
            OP_RESERVE:
            begin
                if (cnt_ext > sp_ext)
                begin
                    err_code = ERR_OVER;
                end
            end
            OP_DROP, OP_REVERSE:
            begin
                if (cnt_ext > occ_ext)
                begin
                    err_code = ERR_UNDER;
                end
            end
            OP_PEEK_TOP, OP_PEEK_BOT:
            begin
                if (cnt_ext >= occ_ext)
                begin
                    err_code = ERR_UNDER;
                end
            end
            default:
            begin
                err_code = ERR_OK;
            end
        endcase
    end

    // pointer after the request
    always_comb
    begin
        sp_next = sp_reg;
        if (err_code == ERR_OK)
        begin
            unique case (req_reg.opcode)
                OP_PUSH:    sp_next = sp_reg - SP_BITS'(1);
                OP_POP:     sp_next = sp_reg + SP_BITS'(1);
                OP_RESERVE: sp_next = SP_BITS'(sp_ext - cnt_ext);
                OP_DROP:    sp_next = SP_BITS'(sp_ext + cnt_ext);
                default:    sp_next = sp_reg;
            endcase
        end
    end

    // address of pop and peek reads
    always_comb
    begin
        priority if (req_reg.opcode == OP_PEEK_BOT)
        begin
            op_addr = ADDR_BITS'(CMP_BITS'(DEPTH - 1) - cnt_ext);
        end
        else if (req_reg.opcode == OP_PEEK_TOP)
        begin
            op_addr = ADDR_BITS'(sp_ext + cnt_ext);
        end
        else
        begin
            op_addr = ADDR_BITS'(sp_reg);
        end
    end

    // store write port select
    assign push_write = cmd.finish && req_reg.opcode == OP_PUSH && err_code == ERR_OK;
    assign mem_we     = cmd.clr_write || cmd.wr_lo || cmd.wr_hi || push_write;

    always_comb
    begin
        priority if (cmd.clr_write)
        begin
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else if (cmd.wr_lo)
        begin
            mem_waddr = lo_reg;
            mem_wdata = rdata_reg;
        end
        else if (cmd.wr_hi)
        begin
            mem_waddr = hi_reg;
            mem_wdata = tmp_reg;
        end
        else
        begin
            mem_waddr = ADDR_BITS'(sp_reg - SP_BITS'(1));
            mem_wdata = req_reg.value[WORD_BITS-1:0];
        end
    end

    // store read port select
    assign mem_re = cmd.rd_op || cmd.rd_lo || cmd.rd_hi;

    always_comb
    begin
        priority if (cmd.rd_op)
        begin
            mem_raddr = op_addr;
        end
        else if (cmd.rd_lo)
        begin
            mem_raddr = lo_reg;
        end
        else
        begin
            mem_raddr = hi_reg;
        end
    end

    // store write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // request, swap and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        if (cmd.rev_init)
        begin
            lo_reg <= ADDR_BITS'(sp_reg);
            hi_reg <= ADDR_BITS'(sp_ext + cnt_ext - CMP_BITS'(1));
        end
        else if (cmd.wr_hi)
        begin
            lo_reg <= lo_reg + ADDR_BITS'(1);
            hi_reg <= hi_reg - ADDR_BITS'(1);
        end
        if (cmd.rd_hi)
        begin
            tmp_reg <= rdata_reg;
        end
        if (cmd.finish)
        begin
            result_reg.data      <= cmd.fin_rdata ? DATA_BITS'(rdata_reg) : '0;
            result_reg.error     <= err_code;
            result_reg.occupancy <= OCC_BITS'(SP_BITS'(DEPTH) - sp_next);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg      <= SP_BITS'(DEPTH);
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.finish)
            begin
                sp_reg <= sp_next;
            end
            if (cmd.clr_write)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_BITS'(1);
            end
        end
    end

    // status to the controller
    assign status.opcode    = req_reg.opcode;
    assign status.fault     = (err_code != ERR_OK);
    assign status.rev_multi = (cnt_ext > CMP_BITS'(1));
    assign status.lo_lt_hi  = (lo_reg < hi_reg);
    assign status.clr_last  = (clr_cnt_reg == ADDR_BITS'(DEPTH - 1));

    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

// ===== src/operand_stack_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// operand_stack_engine
// Downward-growing operand stack of 64-bit words for a bytecode interpreter:
// push, pop, reserve, drop, reverse top and peek, with error and occupancy.
// ----------------------------------------------------------------------------
//  channel   handshake            word
//  request   start, busy          req    (opcode, value, count)
//  result    done (one cycle)     result (data, error, occupancy)
//
//  A word is taken when start is high and busy is low; its result is shown
//  for one cycle on done. Push, reserve, drop, errors, unused opcodes and
//  reverse of fewer than 2 words finish after decode; pop and peek add one
//  registered store read; reverse of n > 1 words walks a swap loop for each
//  word pair: read lower, read upper, write lower, write upper.
//  After reset busy stays high while the store is zeroed.
//  The receiver cannot stall; busy low again once the result is out.
// ----------------------------------------------------------------------------
module operand_stack_engine (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            start,
    output logic           busy,
    input  ose_pkg::req_t  req,
    output logic           done,
    output ose_pkg::res_t  result
);
    import ose_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    // sequencing
    ose_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // store and arithmetic
    ose_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .cmd    (cmd),
        .status (status),
        .done   (done),
        .result (result)
    );

endmodule
`default_nettype wire

// ===== tb/operand_stack_engine_test.sv =====
// ----------------------------------------------------------------------------
// operand_stack_engine_test
// Self-checking bench for the operand stack engine. A queue of request words,
// directed corner cases first and then random runs steered around a drifting
// target occupancy, feeds a driver. A monitor tracks the words the engine
// takes, keeps its own copy of the stack to work out each result, and
// compares every strobed result field by field, in order.
// ----------------------------------------------------------------------------
module operand_stack_engine_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ose_pkg::*;

    // opcode the engine treats as a no-op
    localparam logic [OPCODE_BITS-1:0] OP_UNUSED = 3'd7;
    localparam logic [63:0] WORD_MASK = {64{1'b1}} >> (64 - WORD_BITS);
    localparam int RANDOM_WORDS = 1850;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 40;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t req = '0;
    logic busy;
    logic done;
    res_t result;

    // words waiting to be driven and results still owed by the engine
    req_t pending_words[$];
    res_t owed_results[$];

    int unsigned words_sent = 0;
    int unsigned words_taken = 0;
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    int unsigned idle_pct = 0;

    // shadow stack: store and top index, DEPTH meaning empty
    logic [WORD_BITS-1:0] shadow_mem [DEPTH];
    int unsigned shadow_top = DEPTH;

    operand_stack_engine dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .req    (req),
        .done   (done),
        .result (result)
    );

    // clock and the single reset pulse
    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("[%0t] %s: got %h, expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // apply one request word to the shadow stack and return its result word
    function automatic res_t stack_apply(req_t w);
        res_t r;
        int unsigned sp;
        int unsigned occ;
        int unsigned cnt;
        int unsigned lo;
        int unsigned hi;
        logic [WORD_BITS-1:0] t;
        sp = shadow_top;
        occ = DEPTH - sp;
        cnt = w.count;
        r = '0;
        r.error = ERR_OK;
        case (w.opcode)
            OP_PUSH:
            begin
                if (sp == 0)
                    r.error = ERR_OVER;
                else
                begin
                    sp--;
                    shadow_mem[sp] = w.value & WORD_MASK;
                end
            end
            OP_POP:
            begin
                if (occ == 0)
                    r.error = ERR_UNDER;
                else
                begin
                    r.data = shadow_mem[sp];
                    sp++;
                end
            end
            OP_RESERVE:
            begin
                if (cnt > sp)
                    r.error = ERR_OVER;
                else
                    sp -= cnt;
            end
            OP_DROP:
            begin
                if (cnt > occ)
                    r.error = ERR_UNDER;
                else
                    sp += cnt;
            end
            OP_REVERSE:
            begin
                if (cnt > occ)
                    r.error = ERR_UNDER;
                else if (cnt > 1)
                begin
                    lo = sp;
                    hi = sp + cnt - 1;
                    while (lo < hi)
                    begin
                        t = shadow_mem[hi];
                        shadow_mem[hi] = shadow_mem[lo];
                        shadow_mem[lo] = t;
                        lo++;
                        hi--;
                    end
                end
            end
            OP_PEEK_TOP:
            begin
                if (cnt >= occ)
                    r.error = ERR_UNDER;
                else
                    r.data = shadow_mem[sp + cnt];
            end
            OP_PEEK_BOT:
            begin
                if (cnt >= occ)
                    r.error = ERR_UNDER;
                else
                    r.data = shadow_mem[DEPTH - 1 - cnt];
            end
            default:
            begin
            end
        endcase
        shadow_top = sp;
        r.data = r.data & WORD_MASK;
        r.occupancy = OCC_BITS'(DEPTH - sp);
        return r;
    endfunction

    // driver: hold a word until taken, then maybe idle, then the next word
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (words_taken == words_sent)
        begin
            if (pending_words.size() != 0 && $urandom_range(99, 0) >= idle_pct)
            begin
                req <= pending_words.pop_front();
                start <= 1'b1;
                words_sent++;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: check strobed results, then predict for a word taken now
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && done === 1'b1)
        begin
            if (owed_results.size() == 0)
                report_mismatch("result with nothing owed", result.data, 64'd0);
            else
            begin
                want = owed_results.pop_front();
                if (result.data !== want.data)
                    report_mismatch("data", result.data, want.data);
                if (result.error !== want.error)
                    report_mismatch("error", 64'(result.error), 64'(want.error));
                if (result.occupancy !== want.occupancy)
                    report_mismatch("occupancy", 64'(result.occupancy),
                        64'(want.occupancy));
            end
        end
        if (rst_n && start === 1'b1 && busy === 1'b0)
        begin
            owed_results.push_back(stack_apply(req));
            words_taken++;
        end
    end

    function automatic req_t make_word(logic [OPCODE_BITS-1:0] op, logic [63:0] v,
        int unsigned c);
        req_t w;
        w.opcode = op;
        w.value = v;
        w.count = COUNT_BITS'(c);
        return w;
    endfunction

    // random word steered toward a target occupancy
    function automatic req_t make_random(int unsigned occ, int unsigned target);
        int unsigned r;
        int unsigned room;
        logic [63:0] v;
        logic grow;
        r = $urandom_range(99, 0);
        room = DEPTH - occ;
        grow = (occ < target);
        v = {$urandom, $urandom};
        case ($urandom_range(15, 0))
            0: v = '0;
            1: v = '1;
            default: ;
        endcase
        if (r < 28)
            return make_word(grow ? OP_PUSH : OP_POP, v, $urandom_range(2047, 0));
        else if (r < 38)
            return make_word(grow ? OP_RESERVE : OP_DROP, v, $urandom_range(6, 0));
        else if (r < 46)
            return make_word(grow ? OP_POP : OP_PUSH, v, $urandom_range(2047, 0));
        else if (r < 60)
            return make_word(OP_PEEK_TOP, v, $urandom_range(occ, 0));
        else if (r < 72)
            return make_word(OP_PEEK_BOT, v, $urandom_range(occ, 0));
        else if (r < 84)
        begin
            if ($urandom_range(19, 0) == 0)
                return make_word(OP_REVERSE, v, $urandom_range(occ + 1, 0));
            return make_word(OP_REVERSE, v, $urandom_range((occ < 12) ? occ + 1 : 12, 0));
        end
        else if (r < 90)
        begin
            if (grow)
                return make_word(OP_RESERVE, v, $urandom_range(room + 1, 0));
            return make_word(OP_DROP, v, $urandom_range(occ + 1, 0));
        end
        else if (r < 96)
            return make_word(OPCODE_BITS'($urandom_range(7, 0)), v,
                $urandom_range(2047, 0));
        return make_word(OP_UNUSED, v, $urandom_range(2047, 0));
    endfunction

    // stimulus: directed corners, random phases, then drain and verdict
    initial
    begin
        int unsigned phase_idle [4];
        int unsigned target;
        int unsigned made;
        phase_idle = '{0, 72, 27, 0};
        // the engine zeroes its store after reset
        foreach (shadow_mem[i])
            shadow_mem[i] = '0;
        // empty-stack errors and zero counts
        pending_words.push_back(make_word(OP_POP, '1, 0));
        pending_words.push_back(make_word(OP_DROP, '0, 1));
        pending_words.push_back(make_word(OP_PEEK_TOP, '0, 0));
        pending_words.push_back(make_word(OP_PEEK_BOT, '0, 0));
        pending_words.push_back(make_word(OP_REVERSE, '0, 0));
        pending_words.push_back(make_word(OP_RESERVE, '0, 0));
        pending_words.push_back(make_word(OP_DROP, '0, 0));
        // extreme words, peeks at and past the edge, short reverses
        pending_words.push_back(make_word(OP_PUSH, 64'd0, 0));
        pending_words.push_back(make_word(OP_PUSH, '1, 2047));
        pending_words.push_back(make_word(OP_PUSH, 64'hAAAA_AAAA_AAAA_AAAA, 0));
        pending_words.push_back(make_word(OP_PUSH, 64'h5555_5555_5555_5555, 0));
        pending_words.push_back(make_word(OP_PEEK_TOP, '0, 3));
        pending_words.push_back(make_word(OP_PEEK_TOP, '0, 4));
        pending_words.push_back(make_word(OP_PEEK_BOT, '0, 3));
        pending_words.push_back(make_word(OP_REVERSE, '0, 4));
        pending_words.push_back(make_word(OP_REVERSE, '0, 1));
        pending_words.push_back(make_word(OP_POP, '0, 0));
        pending_words.push_back(make_word(OP_UNUSED, '1, 2047));
        // oversized counts
        pending_words.push_back(make_word(OP_RESERVE, '0, 2047));
        pending_words.push_back(make_word(OP_DROP, '0, 2047));
        pending_words.push_back(make_word(OP_REVERSE, '0, 2047));
        // fill to the brim, overflow, full-depth peeks and reverse, empty again
        pending_words.push_back(make_word(OP_RESERVE, '0, DEPTH - 3));
        pending_words.push_back(make_word(OP_PUSH, '1, 0));
        pending_words.push_back(make_word(OP_RESERVE, '0, 1));
        pending_words.push_back(make_word(OP_PEEK_BOT, '0, DEPTH - 1));
        pending_words.push_back(make_word(OP_PEEK_TOP, '0, DEPTH));
        pending_words.push_back(make_word(OP_REVERSE, '0, DEPTH));
        pending_words.push_back(make_word(OP_PEEK_TOP, '0, DEPTH - 1));
        pending_words.push_back(make_word(OP_DROP, '0, DEPTH));

        target = 0;
        for (int p = 0; p < 4; p++)
        begin
            idle_pct = phase_idle[p];
            for (made = 0; made < RANDOM_WORDS / 4; made++)
            begin
                if (made % 150 == 0)
                begin
                    case ($urandom_range(3, 0))
                        0: target = 0;
                        1: target = DEPTH;
                        default: target = $urandom_range(DEPTH, 0);
                    endcase
                end
                while (pending_words.size() >= 2)
                    @(posedge clk);
                pending_words.push_back(make_random(DEPTH - shadow_top, target));
            end
        end

        while (pending_words.size() != 0 || words_taken != words_sent
            || owed_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
src/ose_pkg.sv
src/ose_ctrl.sv
src/ose_dp.sv
src/operand_stack_engine.sv
tb/operand_stack_engine_test.sv
